// File: src/julia_escape_time_iterator_unit_defines.svh
// Assertion macros used by the escape-time iterator controller.
`ifndef JULIA_ESCAPE_TIME_ITERATOR_UNIT_DEFINES_SVH
`define JULIA_ESCAPE_TIME_ITERATOR_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JETI_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JETI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/jeti_pkg.sv
// Package: widths, register codes, shared types and the z saturation function of the escape-time iterator.
package jeti_pkg;

   localparam int FRAC_BITS       = 28;
   localparam int Z_W             = 32;
   localparam int C_W             = 30;
   localparam int ITER_W          = 16;
   localparam int MAG_W           = 35;
   localparam int PERIOD_INTERVAL = 20;
   localparam int PC_W            = $clog2(PERIOD_INTERVAL + 1);
   localparam int PROD_W          = 2 * Z_W;
   // square shifted down by FRAC_BITS; the product never exceeds 2^62
   localparam int SQ_W            = PROD_W - FRAC_BITS - 1;
   localparam int SUM_W           = SQ_W + 1;
   localparam int NEXT_W          = SQ_W + 2;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = C_W;

   localparam logic [ITER_W-1:0] MAX_ITER_RESET = ITER_W'(256);
   localparam logic [SUM_W-1:0]  ESCAPE_LIMIT   = SUM_W'(4) << FRAC_BITS;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_C_REAL   = 2'd0,
      CSR_C_IMAG   = 2'd1,
      CSR_MAX_ITER = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic square;
      logic step;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic finish;
   } dp_status_type;

   // clamp a wide signed sum to the z range
   function automatic logic signed [Z_W-1:0] sat_z(input logic signed [NEXT_W-1:0] v);
      logic signed [Z_W-1:0] r;
      if (v[NEXT_W-1:Z_W-1] == {(NEXT_W-Z_W+1){1'b0}} ||
          v[NEXT_W-1:Z_W-1] == {(NEXT_W-Z_W+1){1'b1}}) begin
         r = v[Z_W-1:0];
      end else if (v[NEXT_W-1]) begin
         r = {1'b1, {(Z_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(Z_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// File: src/jeti_if.sv
// Stream interfaces for the pixel request and result channels.
interface jeti_req_if import jeti_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic signed [Z_W-1:0] start_real;
   logic signed [Z_W-1:0] start_imag;

   modport source (output valid, output start_real, output start_imag, input ready);
   modport sink (input valid, input start_real, input start_imag, output ready);
endinterface

interface jeti_rsp_if import jeti_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ITER_W-1:0] iteration_count;
   logic              escaped;
   logic [MAG_W-1:0]  final_magnitude_sq;

   modport source (output valid, output iteration_count, output escaped,
                   output final_magnitude_sq, input ready);
   modport sink (input valid, input iteration_count, input escaped,
                 input final_magnitude_sq, output ready);
endinterface

// File: src/jeti_datapath.sv
// Datapath: configuration registers, z iteration, cycle check and result word.
module jeti_datapath import jeti_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  dp_cmd_type                   cmd,
   output dp_status_type                status,
   input  logic signed [Z_W-1:0]        start_real,
   input  logic signed [Z_W-1:0]        start_imag,
   input  logic                         csr_write_enable,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_write_data,
   output logic [ITER_W-1:0]            iteration_count,
   output logic                         escaped,
   output logic [MAG_W-1:0]             final_magnitude_sq
);

   logic signed [C_W-1:0]    c_real_ff, c_imag_ff;
   logic [ITER_W-1:0]        max_iter_ff;
   logic signed [Z_W-1:0]    z_real_ff, z_imag_ff, z_real_in, z_imag_in;
   logic signed [Z_W-1:0]    saved_real_ff, saved_imag_ff;
   logic [ITER_W-1:0]        iter_ff;
   logic [PC_W-1:0]          pc_ff;
   logic signed [PROD_W-1:0] prod_rr_ff, prod_ii_ff, prod_ri_ff;
   logic [ITER_W-1:0]        out_count_ff;
   logic                     out_escaped_ff;
   logic [MAG_W-1:0]         out_mag_ff;

   logic [SQ_W-1:0]          rr, ii;
   logic [SUM_W-1:0]         mag;
   logic signed [PROD_W-1:0] cross_full;
   logic signed [NEXT_W-1:0] cross_term, re_sum, im_sum;
   logic                     hit;

   assign rr         = prod_rr_ff[FRAC_BITS +: SQ_W];
   assign ii         = prod_ii_ff[FRAC_BITS +: SQ_W];
   assign mag        = {1'b0, rr} + {1'b0, ii};
   assign cross_full = prod_ri_ff >>> (FRAC_BITS - 1);
   assign cross_term = cross_full[NEXT_W-1:0];
   assign re_sum     = $signed({2'b00, rr}) - $signed({2'b00, ii})
                       + $signed({{(NEXT_W-C_W){c_real_ff[C_W-1]}}, c_real_ff});
   assign im_sum     = cross_term
                       + $signed({{(NEXT_W-C_W){c_imag_ff[C_W-1]}}, c_imag_ff});
   assign z_real_in  = sat_z(re_sum);
   assign z_imag_in  = sat_z(im_sum);
   assign hit        = (z_real_in == saved_real_ff) && (z_imag_in == saved_imag_ff);

   assign status.finish = (mag >= ESCAPE_LIMIT) || (iter_ff >= max_iter_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_real_ff   <= '0;
         c_imag_ff   <= '0;
         max_iter_ff <= MAX_ITER_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_C_REAL:   c_real_ff   <= csr_write_data;
            CSR_C_IMAG:   c_imag_ff   <= csr_write_data;
            CSR_MAX_ITER: max_iter_ff <= csr_write_data[ITER_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         z_real_ff     <= start_real;
         z_imag_ff     <= start_imag;
         iter_ff       <= '0;
         saved_real_ff <= '0;
         saved_imag_ff <= '0;
         pc_ff         <= '0;
      end else if (cmd.step) begin
         z_real_ff <= z_real_in;
         z_imag_ff <= z_imag_in;
         if (hit) begin
            // cycle found: jump to the limit so the next check stops
            iter_ff <= max_iter_ff;
         end else begin
            iter_ff <= iter_ff + ITER_W'(1);
            if (pc_ff >= PC_W'(PERIOD_INTERVAL)) begin
               pc_ff         <= '0;
               saved_real_ff <= z_real_in;
               saved_imag_ff <= z_imag_in;
            end else begin
               pc_ff <= pc_ff + PC_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         prod_rr_ff <= z_real_ff * z_real_ff;
         prod_ii_ff <= z_imag_ff * z_imag_ff;
         prod_ri_ff <= z_real_ff * z_imag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_count_ff   <= iter_ff;
         out_escaped_ff <= (mag >= ESCAPE_LIMIT);
         out_mag_ff     <= mag[MAG_W] ? {MAG_W{1'b1}} : mag[MAG_W-1:0];
      end
   end

   assign iteration_count    = out_count_ff;
   assign escaped            = out_escaped_ff;
   assign final_magnitude_sq = out_mag_ff;

endmodule

// File: src/jeti_ctrl.sv
// Controller: sequences load, square and step phases and owns the result handshake.
`include "julia_escape_time_iterator_unit_defines.svh"

module jeti_ctrl import jeti_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SQUARE = 4'b0010,
      ST_STEP   = 4'b0100,
      ST_HOLD   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      accept, out_free, done;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign done      = ((state_ff == ST_STEP) && status.finish) || (state_ff == ST_HOLD);

   assign cmd.load     = accept;
   assign cmd.square   = (state_ff == ST_SQUARE);
   assign cmd.step     = (state_ff == ST_STEP) && !status.finish;
   assign cmd.out_load = done && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (!status.finish) state_in = ST_SQUARE;
            else if (out_free) state_in = ST_IDLE;
            else state_in = ST_HOLD;
         end
         ST_HOLD: begin
            // wait for the previous result word to drain
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

   `JETI_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_valid_ff || rsp_ready, "result word overwritten before taken")
   `JETI_ASSERT_NEXT(a_accept_square, accept, state_ff == ST_SQUARE, "accepted word did not start squaring")
   `JETI_ASSERT_SAME(a_hold_busy, state_ff == ST_HOLD, out_valid_ff, "holding while result register empty")
   `JETI_ASSERT_NEXT(a_step_loop, cmd.step, state_ff == ST_SQUARE, "step not followed by square")

endmodule

// File: src/julia_escape_time_iterator_unit.sv
// Top level of the Julia-set escape-time iterator.
//
// Usage: write c_real, c_imag and max_iterations through the csr_ port while
// the block is idle (index 0, 1, 2; other indexes are ignored). Each word on
// req carries a starting point z in signed Q4.28. One result word on rsp
// follows each request: the iteration count, the escaped flag and the final
// |z|^2 in unsigned Q7.28, saturated.
// Each iteration has two steps: the square state forms the three 32x32
// products, the step state forms |z|^2, the escape and limit test and the
// new z. A request is accepted only while the block is idle, so a pixel is
// iterated to its end before the next one is taken.
// Reset (synchronous, active high) clears c to zero, sets the limit to 256
// and empties the result register. A finished result waits in its own
// register while the next pixel is accepted and iterated; if rsp stalls and
// a second result is ready, the block holds it and takes no new request.
module julia_escape_time_iterator_unit import jeti_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   jeti_req_if.sink              req,
   jeti_rsp_if.source            rsp,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   jeti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   jeti_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .start_real         (req.start_real),
      .start_imag         (req.start_imag),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .iteration_count    (rsp.iteration_count),
      .escaped            (rsp.escaped),
      .final_magnitude_sq (rsp.final_magnitude_sq)
   );

endmodule

// File: bench/julia_escape_time_iterator_unit_test.sv
// Self-checking bench for the Julia escape-time iterator: directed and random pixels.
module julia_escape_time_iterator_unit_test;
   import jeti_pkg::*;

   localparam int WATCHDOG_LIMIT = 600000;
   localparam int HOLD_AT_RESULT = 350;
   localparam int HOLD_CYCLES    = 2000;
   localparam int SETTLE_CYCLES  = 20;

   localparam logic [Z_W-1:0] Q_ONE      = 32'h1000_0000;
   localparam logic [Z_W-1:0] Q_TWO      = 32'h2000_0000;
   localparam logic [Z_W-1:0] Z_MOST_NEG = 32'h8000_0000;
   localparam logic [Z_W-1:0] Z_MOST_POS = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [ITER_W-1:0] count;
      logic              escaped;
      logic [MAG_W-1:0]  magnitude;
   } pixel_result_type;

   class escape_time_tracker_type;
      localparam longint ESCAPE_SQ = longint'(4) << FRAC_BITS;
      localparam longint Z_TOP     = (longint'(1) << (Z_W - 1)) - 1;
      localparam longint Z_BOTTOM  = -(longint'(1) << (Z_W - 1));
      localparam longint MAG_TOP   = (longint'(1) << MAG_W) - 1;

      pixel_result_type expected_results[$];
      longint        c_re;
      longint        c_im;
      int unsigned   iter_limit;
      int            errors;

      function new();
         c_re = 0;
         c_im = 0;
         iter_limit = 256;
         errors = 0;
      endfunction

      function void set_config(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_C_REAL: c_re = longint'(signed'(data[C_W-1:0]));
            CSR_C_IMAG: c_im = longint'(signed'(data[C_W-1:0]));
            CSR_MAX_ITER: iter_limit = data[ITER_W-1:0];
            default: ;
         endcase
      endfunction

      function longint clamp_z(longint v);
         if (v > Z_TOP) return Z_TOP;
         if (v < Z_BOTTOM) return Z_BOTTOM;
         return v;
      endfunction

      // iterate one pixel and queue its result
      function void note_pixel(logic [Z_W-1:0] sr, logic [Z_W-1:0] si);
         longint zr, zi, rr, ii, cross_term, nr, ni, saved_r, saved_i, mag;
         int unsigned count, phase;
         pixel_result_type res;
         zr = longint'(signed'(sr));
         zi = longint'(signed'(si));
         count = 0;
         phase = 0;
         saved_r = 0;
         saved_i = 0;
         rr = (zr * zr) >>> FRAC_BITS;
         ii = (zi * zi) >>> FRAC_BITS;
         while (rr + ii < ESCAPE_SQ && count < iter_limit) begin
            cross_term = (zr * zi) >>> (FRAC_BITS - 1);
            nr = clamp_z(rr - ii + c_re);
            ni = clamp_z(cross_term + c_im);
            zr = nr;
            zi = ni;
            rr = (zr * zr) >>> FRAC_BITS;
            ii = (zi * zi) >>> FRAC_BITS;
            count++;
            // exact repeat of the saved point: treat as bounded
            if (zr == saved_r && zi == saved_i) begin
               count = iter_limit;
               break;
            end
            if (phase >= PERIOD_INTERVAL) begin
               phase = 0;
               saved_r = zr;
               saved_i = zi;
            end else begin
               phase++;
            end
         end
         mag = rr + ii;
         res.count = count[ITER_W-1:0];
         res.escaped = (mag >= ESCAPE_SQ);
         res.magnitude = (mag > MAG_TOP) ? MAG_TOP[MAG_W-1:0] : mag[MAG_W-1:0];
         expected_results.push_back(res);
      endfunction

      function void check_result(logic [ITER_W-1:0] count, logic escaped,
                                 logic [MAG_W-1:0] magnitude);
         pixel_result_type want;
         if (expected_results.size() == 0) begin
            $error("result word with no pixel outstanding: count %0d", count);
            errors++;
            return;
         end
         want = expected_results.pop_front();
         if (count !== want.count) begin
            $error("iteration_count: expected %0d, actual %0d", want.count, count);
            errors++;
         end
         if (escaped !== want.escaped) begin
            $error("escaped: expected %0b, actual %0b", want.escaped, escaped);
            errors++;
         end
         if (magnitude !== want.magnitude) begin
            $error("final_magnitude_sq: expected %0h, actual %0h", want.magnitude, magnitude);
            errors++;
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   jeti_req_if req_if ();
   jeti_rsp_if rsp_if ();

   julia_escape_time_iterator_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   escape_time_tracker_type tracker = new();
   int pixels_sent = 0;
   int results_seen = 0;
   int send_idle_pct = 13;
   int recv_idle_pct = 87;
   int stall_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receive side: random back-pressure plus one long hold-off
   initial begin
      int hold;
      hold = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            tracker.check_result(rsp_if.iteration_count, rsp_if.escaped,
                                 rsp_if.final_magnitude_sq);
            results_seen++;
            if (results_seen == HOLD_AT_RESULT) hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // count cycles with no word moving on either channel
   initial begin
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("julia_escape_time_iterator_unit verification failed");
            $finish;
         end
      end
   end

   task automatic send_pixel(logic [Z_W-1:0] sr, logic [Z_W-1:0] si);
      if (pixels_sent < 383) begin
         send_idle_pct = 13;
         recv_idle_pct = 87;
      end else if (pixels_sent < 766) begin
         send_idle_pct = 87;
         recv_idle_pct = 13;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.start_real <= sr;
      req_if.start_imag <= si;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      tracker.note_pixel(sr, si);
      pixels_sent++;
   endtask

   // hold the request side until every outstanding result is back
   task automatic drain();
      req_if.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      tracker.set_config(idx, data);
   endtask

   task automatic apply_config(logic [C_W-1:0] cr, logic [C_W-1:0] ci,
                               logic [ITER_W-1:0] limit);
      drain();
      write_csr(CSR_C_REAL, cr);
      write_csr(CSR_C_IMAG, ci);
      write_csr(CSR_MAX_ITER, CSR_DATA_W'(limit));
      csr_write_enable <= 1'b0;
   endtask

   // mostly components within plus or minus two, some full-range noise
   function automatic logic [Z_W-1:0] random_start(int wide_pct);
      if ($urandom_range(99) < wide_pct) return $urandom();
      return Z_W'(longint'($urandom_range(32'h3FFF_FFFF)) - (longint'(1) << 29));
   endfunction

   task automatic run_random(logic [C_W-1:0] cr, logic [C_W-1:0] ci,
                             logic [ITER_W-1:0] limit, int count, int wide_pct);
      apply_config(cr, ci, limit);
      repeat (count) send_pixel(random_start(wide_pct), random_start(wide_pct));
   endtask

   initial begin
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_C_REAL;
      csr_write_data <= '0;
      req_if.valid <= 1'b0;
      req_if.start_real <= '0;
      req_if.start_imag <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // c = 0 at the default limit: fixed points, zero start, extremes
      apply_config('0, '0, 16'd256);
      send_pixel('0, '0);
      send_pixel(Q_ONE, '0);
      send_pixel('0, Q_ONE);
      send_pixel(Q_TWO, '0);
      send_pixel(Z_MOST_NEG, Z_MOST_NEG);
      send_pixel(Z_MOST_POS, Z_MOST_POS);
      send_pixel(Z_MOST_NEG, '0);
      send_pixel('0, Z_MOST_POS);
      send_pixel('1, '1);
      send_pixel(32'd1, 32'd1);
      send_pixel(Q_ONE >> 1, Q_ONE >> 1);
      // zero limit: magnitude of the start only
      apply_config('0, '0, '0);
      send_pixel(Q_ONE, Q_ONE);
      send_pixel(Z_MOST_NEG, Z_MOST_POS);
      // limit of one: escape on the last permitted step, and a start that stays bounded
      apply_config('0, '0, 16'd1);
      send_pixel(32'h1800_0000, '0);
      send_pixel(32'h0400_0000, '0);
      // extreme c with the widest limit
      apply_config(30'h2000_0000, 30'h1FFF_FFFF, 16'hFFFF);
      send_pixel('0, '0);
      send_pixel(Z_MOST_POS, Z_MOST_NEG);
      // c = -1: z alternates between zero and minus one
      apply_config(30'h3000_0000, '0, 16'd256);
      send_pixel('0, '0);

      // c = -0.12 + 0.75i
      run_random(-30'sd32212255, 30'sd201326592, 16'd256, 150, 10);
      // c = 0.3: every point escapes, so the widest limit stays cheap
      run_random(30'sd80530637, '0, 16'hFFFF, 30, 0);
      repeat (6) run_random(C_W'($urandom()), C_W'($urandom()),
                            ITER_W'($urandom_range(64)), 50, 30);
      run_random('0, '0, 16'd16, 100, 20);
      // c = -0.75 + 0.1i
      run_random(-30'sd201326592, 30'sd26843546, 16'd100, 150, 20);
      repeat (6) run_random(C_W'(longint'($urandom_range(32'h1FFF_FFFF)) - (longint'(1) << 28)),
                            C_W'(longint'($urandom_range(32'h1FFF_FFFF)) - (longint'(1) << 28)),
                            ITER_W'($urandom_range(300)), 50, 20);
      run_random(30'h3000_0000, '0, 16'd1000, 100, 20);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("julia_escape_time_iterator_unit verification clean");
      end else begin
         $display("julia_escape_time_iterator_unit verification failed");
      end
      $finish;
   end

endmodule
